// ----- rtl/lhq_pkg.sv -----
// Package for the linked handle queue.
// Holds field widths, operation and status codes, and the controller/datapath
// interface structs. Depends on nothing.
package lhq_pkg;

    localparam int HANDLE_W = 6;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_DRAIN = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DUP   = 2'd2
    } t_status;

    typedef struct packed {
        logic accept;
        logic do_enq;
        logic do_query;
        logic do_empty_resp;
        logic load_item;
        logic deq_pop;
        logic drain_step;
    } t_lhq_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic out_free;
        logic at_tail;
    } t_lhq_sts;

endpackage

// ----- rtl/linked_handle_queue.sv -----
// Linked handle queue: a FIFO of item handles kept as a linked list in a
// next-handle memory, with head, tail, empty flag and one membership bit per
// handle; it takes an input word and returns one or more result words. An
// enqueue, a query, and a dequeue or drain on an empty queue answer from
// S_EXEC; a dequeue goes via S_EXEC and S_DEQ; a drain via S_EXEC, then
// S_DRAIN once per queued handle. The registered next-memory read sets the
// S_DEQ step and a drain pace of one handle per cycle while the output is
// not stalled. The next memory needs no clearing after reset, so words are
// taken right away. Depends on lhq_pkg, lhq_ctrl and lhq_dpath.
module linked_handle_queue
    import lhq_pkg::*;
#(
    parameter int POOL_ITEMS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [HANDLE_W-1:0] i_handle,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_item_handle,
    output logic                o_is_inside,
    output logic                o_is_empty,
    output logic                o_last
);

    t_lhq_cmd cmd;
    t_lhq_sts sts;

    lhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lhq_dpath #(
        .POOL_ITEMS (POOL_ITEMS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_handle      (i_handle),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_item_handle (o_item_handle),
        .o_is_inside   (o_is_inside),
        .o_is_empty    (o_is_empty),
        .o_last        (o_last)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.do_enq, cmd.do_query, cmd.do_empty_resp,
                  cmd.load_item, cmd.deq_pop, cmd.drain_step}))
        else $error("more than one datapath command in one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> o_in_stall)
        else $error("input not stalled after a word was accepted");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> o_is_empty && o_last)
        else $error("empty status without empty flag and last");

    a_mid_drain_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> (o_status == ST_OK) && o_is_empty)
        else $error("non-final drain word with bad status or flag");

endmodule

// ----- rtl/lhq_ctrl.sv -----
// Controller state machine of the linked handle queue.
// Sequences enqueue, dequeue, drain and query words into datapath commands.
// Depends on lhq_pkg.
module lhq_ctrl
    import lhq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_lhq_sts i_sts,
    output t_lhq_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DEQ,
        S_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.op)
                    OP_ENQ: begin
                        if (i_sts.out_free) begin
                            o_cmd.do_enq = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_QUERY: begin
                        if (i_sts.out_free) begin
                            o_cmd.do_query = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    OP_DEQ, OP_DRAIN: begin
                        if (i_sts.empty) begin
                            if (i_sts.out_free) begin
                                o_cmd.do_empty_resp = 1'b1;
                                n_state             = S_IDLE;
                            end
                        end else begin
                            o_cmd.load_item = 1'b1;
                            n_state = (i_sts.op == OP_DEQ) ? S_DEQ : S_DRAIN;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DEQ: begin
                if (i_sts.out_free) begin
                    o_cmd.deq_pop = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (i_sts.out_free) begin
                    o_cmd.drain_step = 1'b1;
                    if (i_sts.at_tail) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/lhq_dpath.sv -----
// Datapath of the linked handle queue.
// Holds the next-handle memory, head, tail, empty flag, membership bits and
// the output word register. Depends on lhq_pkg.
module lhq_dpath
    import lhq_pkg::*;
#(
    parameter int POOL_ITEMS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lhq_cmd            i_cmd,
    output t_lhq_sts            o_sts,
    input  logic [OP_W-1:0]     i_op,
    input  logic [HANDLE_W-1:0] i_handle,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_item_handle,
    output logic                o_is_inside,
    output logic                o_is_empty,
    output logic                o_last
);

    localparam int IDX_W = (POOL_ITEMS > 1) ? $clog2(POOL_ITEMS) : 1;

    logic [HANDLE_W-1:0] r_next_mem [POOL_ITEMS];
    logic [HANDLE_W-1:0] r_rd_data;
    logic [HANDLE_W-1:0] n_item;

    t_op                 r_op;
    logic [HANDLE_W-1:0] r_handle;
    logic [HANDLE_W-1:0] r_item;
    logic [HANDLE_W-1:0] r_head;
    logic [HANDLE_W-1:0] r_tail;
    logic                r_empty;
    logic [POOL_ITEMS-1:0] r_member;

    logic                r_out_valid;
    t_status             r_status;
    logic [HANDLE_W-1:0] r_out_item;
    logic                r_out_inside;
    logic                r_out_empty;
    logic                r_out_last;

    logic in_pool;
    logic member_hit;
    logic enq_bad;
    logic at_tail;
    logic emit;
    logic mem_we;

    assign in_pool    = ({1'b0, r_handle} < (HANDLE_W+1)'(POOL_ITEMS));
    assign member_hit = in_pool && r_member[r_handle[IDX_W-1:0]];
    assign enq_bad    = !in_pool || member_hit;
    assign at_tail    = (r_item == r_tail);
    assign emit       = i_cmd.do_enq || i_cmd.do_query || i_cmd.do_empty_resp ||
                        i_cmd.deq_pop || i_cmd.drain_step;
    assign mem_we     = i_cmd.do_enq && !enq_bad && !r_empty;

    always_comb begin
        priority if (i_cmd.load_item) begin
            n_item = r_head;
        end else if (i_cmd.drain_step) begin
            n_item = r_rd_data;
        end else begin
            n_item = r_item;
        end
    end

    // The read data holds the item's successor, read before any write.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_next_mem[r_tail[IDX_W-1:0]] <= r_handle;
        end
        r_rd_data <= r_next_mem[n_item[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        if (i_cmd.accept) begin
            r_op     <= t_op'(i_op);
            r_handle <= i_handle;
        end
        if (emit) begin
            r_out_item   <= '0;
            r_out_inside <= 1'b0;
            r_out_last   <= 1'b1;
            priority if (i_cmd.do_enq) begin
                r_status    <= enq_bad ? ST_DUP : ST_OK;
                r_out_empty <= enq_bad ? r_empty : 1'b0;
            end else if (i_cmd.do_query) begin
                r_status     <= ST_OK;
                r_out_inside <= member_hit;
                r_out_empty  <= r_empty;
            end else if (i_cmd.do_empty_resp) begin
                r_status    <= ST_EMPTY;
                r_out_empty <= 1'b1;
            end else if (i_cmd.deq_pop) begin
                r_status    <= ST_OK;
                r_out_item  <= r_item;
                r_out_empty <= at_tail;
            end else begin
                r_status    <= ST_OK;
                r_out_item  <= r_item;
                r_out_empty <= 1'b1;
                r_out_last  <= at_tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_member    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.do_enq && !enq_bad) begin
                r_member[r_handle[IDX_W-1:0]] <= 1'b1;
                if (r_empty) begin
                    r_head <= r_handle;
                end
                r_tail  <= r_handle;
                r_empty <= 1'b0;
            end
            if (i_cmd.deq_pop) begin
                r_member[r_item[IDX_W-1:0]] <= 1'b0;
                if (at_tail) begin
                    r_empty <= 1'b1;
                end else begin
                    r_head <= r_rd_data;
                end
            end
            if (i_cmd.drain_step) begin
                r_member[r_item[IDX_W-1:0]] <= 1'b0;
                if (at_tail) begin
                    r_empty <= 1'b1;
                end
            end
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.empty    = r_empty;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.at_tail  = at_tail;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_item_handle = r_out_item;
    assign o_is_inside   = r_out_inside;
    assign o_is_empty    = r_out_empty;
    assign o_last        = r_out_last;

endmodule
